[rtl/cartridge_bank_mapper_core_assert.svh]
// Assertion macros shared by the bank mapper checker
`ifndef CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CBM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bank mapper check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bank mapper check failed");

`endif

[rtl/cbm_pkg.sv]
// Types and constants of the cartridge bank mapper
`default_nettype none
package cbm_pkg;

    typedef enum logic [2:0] {
        KIND_NROM  = 3'd0,
        KIND_MMC1  = 3'd1,
        KIND_UXROM = 3'd2,
        KIND_CNROM = 3'd3,
        KIND_AXROM = 3'd4,
        KIND_GXROM = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        MMC1_CONTROL = 2'd0,
        MMC1_CHR0    = 2'd1,
        MMC1_CHR1    = 2'd2,
        MMC1_PRG     = 2'd3
    } mmc1_reg_t;

    typedef enum logic [1:0] {
        PRG_32K_A  = 2'd0,
        PRG_32K_B  = 2'd1,
        PRG_FIX_LO = 2'd2,
        PRG_FIX_HI = 2'd3
    } prg_mode_t;

    localparam logic CFG_MAPPER_KIND = 1'b0;
    localparam logic CFG_PRG_COUNT   = 1'b1;

    localparam int CFG_DATA_W = 6;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int BANK_W     = 5;
    localparam int MIRROR_W   = 2;

    localparam logic [4:0] SHIFT_EMPTY   = 5'b10000;
    localparam logic [4:0] CTRL_RESET    = 5'h0C;
    localparam logic [4:0] CTRL_PRG_FIX  = 5'h0C;
    localparam logic [2:0] KIND_RESET    = 3'd0;
    localparam logic [5:0] COUNT_RESET   = 6'd2;

endpackage
`default_nettype wire

[rtl/cbm_wr_if.sv]
// CPU write channel: valid/ready handshake with address and data
`default_nettype none
interface cbm_wr_if;
    import cbm_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] cpu_address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output cpu_address, output write_data, input ready);
    modport sink   (input valid, input cpu_address, input write_data, output ready);
endinterface
`default_nettype wire

[rtl/cbm_bank_if.sv]
// Bank result channel: valid/ready handshake with bank numbers and mirroring
`default_nettype none
interface cbm_bank_if;
    import cbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [BANK_W-1:0]   prg_bank_low;
    logic [BANK_W-1:0]   prg_bank_high;
    logic [BANK_W-1:0]   chr_bank_low;
    logic [BANK_W-1:0]   chr_bank_high;
    logic [MIRROR_W-1:0] mirror_mode;

    modport source (output valid, output prg_bank_low, output prg_bank_high,
                    output chr_bank_low, output chr_bank_high, output mirror_mode,
                    input ready);
    modport sink   (input valid, input prg_bank_low, input prg_bank_high,
                    input chr_bank_low, input chr_bank_high, input mirror_mode,
                    output ready);
endinterface
`default_nettype wire

[rtl/cartridge_bank_mapper_core.sv]
// An accepted write goes into the input register, then its bank result into the result register.
// Throughput: one write per clock while the result side is not stalled; input register and result register run as a
// two-stage pipeline, so a stall on the result side holds at most one item in each.
// Reset (rst_n low, asynchronous): pipeline empties, mapper kind NROM, 2 PRG banks,
// MMC1 shift holds its marker, control 0x0C, all bank selects zero.
`default_nettype none
module cartridge_bank_mapper_core
    import cbm_pkg::*;
#(
    parameter int MAX_PRG_BANKS = 32
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire [0:0]             cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    cbm_wr_if.sink                wr,
    cbm_bank_if.source            bank
);

    localparam logic [5:0] MAX_COUNT = 6'(MAX_PRG_BANKS);

    // configuration
    logic [2:0] kind_reg;
    logic [5:0] count_reg;

    // mapper state
    logic [4:0] shift_reg, shift_next;
    logic [4:0] ctrl_reg, ctrl_next;
    logic [4:0] chr0_reg, chr0_next;
    logic [4:0] chr1_reg, chr1_next;
    logic [3:0] prg_reg, prg_next;
    logic [2:0] sprg_reg, sprg_next;
    logic [1:0] schr_reg, schr_next;

    // input stage
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;

    // result stage
    logic                out_valid_reg;
    logic [BANK_W-1:0]   pl_reg, pl_next;
    logic [BANK_W-1:0]   ph_reg, ph_next;
    logic [BANK_W-1:0]   cl_reg, cl_next;
    logic [BANK_W-1:0]   ch_reg, ch_next;
    logic [MIRROR_W-1:0] mir_reg, mir_next;

    logic       s1_fire;
    logic       out_free;
    logic [4:0] shifted;
    logic [5:0] eff_count;
    logic [4:0] last_bank;
    logic [4:0] nrom_high;

    assign out_free = !out_valid_reg || bank.ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign wr.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAPPER_KIND: kind_reg  <= cfg_data[2:0];
                CFG_PRG_COUNT:   count_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (wr.ready)
        begin
            s1_valid_reg <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.ready && wr.valid)
        begin
            addr_reg <= wr.cpu_address;
            data_reg <= wr.write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_EMPTY;
            ctrl_reg  <= CTRL_RESET;
            chr0_reg  <= '0;
            chr1_reg  <= '0;
            prg_reg   <= '0;
            sprg_reg  <= '0;
            schr_reg  <= '0;
        end
        else if (s1_fire)
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            chr0_reg  <= chr0_next;
            chr1_reg  <= chr1_next;
            prg_reg   <= prg_next;
            sprg_reg  <= sprg_next;
            schr_reg  <= schr_next;
        end
    end

    // last bank: count 0 reads as 1, saturates at MAX_PRG_BANKS
    always_comb
    begin
        eff_count = count_reg;
        if (eff_count == 6'd0)
        begin
            eff_count = 6'd1;
        end
        if (eff_count > MAX_COUNT)
        begin
            eff_count = MAX_COUNT;
        end
        last_bank = 5'(eff_count - 6'd1);
        nrom_high = (count_reg == 6'd1) ? 5'd0 : 5'd1;
    end

    // state update for the write in the input register
    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        chr0_next  = chr0_reg;
        chr1_next  = chr1_reg;
        prg_next   = prg_reg;
        sprg_next  = sprg_reg;
        schr_next  = schr_reg;
        shifted    = {data_reg[0], shift_reg[4:1]};
        if (addr_reg[15])
        begin
            unique case (kind_t'(kind_reg))
                KIND_MMC1:
                begin
                    if (data_reg[7])
                    begin
                        shift_next = SHIFT_EMPTY;
                        ctrl_next  = ctrl_reg | CTRL_PRG_FIX;
                    end
                    else if (!shift_reg[0])
                    begin
                        shift_next = shifted;
                    end
                    else
                    begin
                        // marker reached bit 0: fifth write commits
                        shift_next = SHIFT_EMPTY;
                        unique case (mmc1_reg_t'(addr_reg[14:13]))
                            MMC1_CONTROL: ctrl_next = shifted;
                            MMC1_CHR0:    chr0_next = shifted;
                            MMC1_CHR1:    chr1_next = shifted;
                            MMC1_PRG:     prg_next  = shifted[3:0];
                            default:      ;
                        endcase
                    end
                end
                KIND_UXROM, KIND_AXROM: sprg_next = data_reg[2:0];
                KIND_CNROM:             schr_next = data_reg[1:0];
                KIND_GXROM:
                begin
                    sprg_next = {1'b0, data_reg[5:4]};
                    schr_next = data_reg[1:0];
                end
                default: ;
            endcase
        end
    end

    // bank outputs from the updated state
    always_comb
    begin
        pl_next  = '0;
        ph_next  = nrom_high;
        cl_next  = 5'd0;
        ch_next  = 5'd1;
        mir_next = '0;
        unique case (kind_t'(kind_reg))
            KIND_MMC1:
            begin
                unique case (prg_mode_t'(ctrl_next[3:2]))
                    PRG_32K_A, PRG_32K_B:
                    begin
                        pl_next = {1'b0, prg_next[3:1], 1'b0};
                        ph_next = {1'b0, prg_next[3:1], 1'b1};
                    end
                    PRG_FIX_LO:
                    begin
                        pl_next = 5'd0;
                        ph_next = {1'b0, prg_next};
                    end
                    PRG_FIX_HI:
                    begin
                        pl_next = {1'b0, prg_next};
                        ph_next = last_bank;
                    end
                    default: ;
                endcase
                if (ctrl_next[4])
                begin
                    cl_next = chr0_next;
                    ch_next = chr1_next;
                end
                else
                begin
                    cl_next = {chr0_next[4:1], 1'b0};
                    ch_next = {chr0_next[4:1], 1'b1};
                end
                mir_next = ctrl_next[1:0];
            end
            KIND_UXROM:
            begin
                pl_next = {2'b00, sprg_next};
                ph_next = last_bank;
            end
            KIND_CNROM:
            begin
                cl_next = {2'b00, schr_next, 1'b0};
                ch_next = {2'b00, schr_next, 1'b1};
            end
            KIND_AXROM:
            begin
                pl_next = {1'b0, sprg_next, 1'b0};
                ph_next = {1'b0, sprg_next, 1'b1};
            end
            KIND_GXROM:
            begin
                pl_next = {2'b00, sprg_next[1:0], 1'b0};
                ph_next = {2'b00, sprg_next[1:0], 1'b1};
                cl_next = {2'b00, schr_next, 1'b0};
                ch_next = {2'b00, schr_next, 1'b1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
            cl_reg  <= cl_next;
            ch_reg  <= ch_next;
            mir_reg <= mir_next;
        end
    end

    assign bank.valid         = out_valid_reg;
    assign bank.prg_bank_low  = pl_reg;
    assign bank.prg_bank_high = ph_reg;
    assign bank.chr_bank_low  = cl_reg;
    assign bank.chr_bank_high = ch_reg;
    assign bank.mirror_mode   = mir_reg;

endmodule
`default_nettype wire

[rtl/cbm_checker.sv]
// Port-level checker for the bank mapper, bound to the top level
`default_nettype none
`include "cartridge_bank_mapper_core_assert.svh"
module cbm_checker
    import cbm_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  cfg_we,
    input wire [0:0]            cfg_index,
    input wire [CFG_DATA_W-1:0] cfg_data,
    input wire                  wr_valid,
    input wire                  wr_ready,
    input wire                  bank_valid,
    input wire                  bank_ready,
    input wire [BANK_W-1:0]     prg_bank_low,
    input wire [BANK_W-1:0]     prg_bank_high,
    input wire [BANK_W-1:0]     chr_bank_low,
    input wire [BANK_W-1:0]     chr_bank_high,
    input wire [MIRROR_W-1:0]   mirror_mode
);

    logic [2:0] kind_reg;
    logic       wr_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_RESET;
        end
        else if (cfg_we && cfg_index == CFG_MAPPER_KIND)
        begin
            kind_reg <= cfg_data[2:0];
        end
    end

    assign wr_seen = wr_valid && wr_ready;

    // the input side only stalls behind a stalled, full result stage
    `CBM_ASSERT_IMPL(a_ready_stall, !wr_ready, bank_valid && !bank_ready)

    // outside MMC1, CHR is an 8 KB pair and mirroring stays zero
    `CBM_ASSERT_IMPL(a_chr_pair, bank_valid && kind_reg != KIND_MMC1,
        mirror_mode == 2'd0 && !chr_bank_low[0] && chr_bank_high == (chr_bank_low | 5'd1))

    // an accepted transaction reaches the ports through the input and result registers
    `CBM_ASSERT_NEXT(a_latency, wr_seen, ##1 bank_valid)

    // stalled result holds
    `CBM_ASSERT_NEXT(a_out_hold, bank_valid && !bank_ready,
        bank_valid && $stable(prg_bank_low) && $stable(prg_bank_high)
        && $stable(chr_bank_low) && $stable(chr_bank_high) && $stable(mirror_mode))

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .wr_valid      (wr.valid),
    .wr_ready      (wr.ready),
    .bank_valid    (bank.valid),
    .bank_ready    (bank.ready),
    .prg_bank_low  (bank.prg_bank_low),
    .prg_bank_high (bank.prg_bank_high),
    .chr_bank_low  (bank.chr_bank_low),
    .chr_bank_high (bank.chr_bank_high),
    .mirror_mode   (bank.mirror_mode)
);
`default_nettype wire

[verif/cartridge_bank_mapper_core_checker.sv]
// Bank mapper checker: predicts the bank map after every accepted CPU write and compares it
module cartridge_bank_mapper_core_checker
    import cbm_pkg::*;
#(
    parameter int MAX_PRG_BANKS = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire [0:0]            cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    cbm_wr_if                    wr,
    cbm_bank_if                  bank,
    output int                   mismatch_count,
    output int                   pending_count
);

    typedef struct packed {
        logic [BANK_W-1:0]   prg_lo;
        logic [BANK_W-1:0]   prg_hi;
        logic [BANK_W-1:0]   chr_lo;
        logic [BANK_W-1:0]   chr_hi;
        logic [MIRROR_W-1:0] mirror;
    } bank_map_t;

    logic [2:0] kind_reg;
    logic [5:0] prg_count;
    logic [4:0] shift_reg;
    logic [4:0] mmc1_ctrl;
    logic [4:0] mmc1_chr0;
    logic [4:0] mmc1_chr1;
    logic [3:0] mmc1_prg;
    logic [2:0] plain_prg;
    logic [1:0] plain_chr;

    bank_map_t expected_maps[$];
    int        errors  = 0;
    int        backlog = 0;

    assign mismatch_count = errors;
    assign pending_count  = backlog;

    function automatic logic [4:0] last_prg_bank();
        int n;
        n = prg_count;
        if (n == 0)
            n = 1;
        if (n > MAX_PRG_BANKS)
            n = MAX_PRG_BANKS;
        return 5'(n - 1);
    endfunction

    function automatic void mmc1_serial_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        logic [4:0] loaded;
        loaded = {data[0], shift_reg[4:1]};
        if (data[7])
        begin
            shift_reg = SHIFT_EMPTY;
            mmc1_ctrl = mmc1_ctrl | CTRL_PRG_FIX;
        end
        else if (!shift_reg[0])
            shift_reg = loaded;
        else
        begin
            // marker reached bit 0: fifth write commits to the register picked by A14..A13
            case (mmc1_reg_t'(addr[14:13]))
                MMC1_CONTROL: mmc1_ctrl = loaded;
                MMC1_CHR0:    mmc1_chr0 = loaded;
                MMC1_CHR1:    mmc1_chr1 = loaded;
                default:      mmc1_prg  = loaded[3:0];
            endcase
            shift_reg = SHIFT_EMPTY;
        end
    endfunction

    function automatic void absorb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        if (addr[15])
        begin
            case (kind_t'(kind_reg))
                KIND_MMC1:  mmc1_serial_write(addr, data);
                KIND_UXROM,
                KIND_AXROM: plain_prg = data[2:0];
                KIND_CNROM: plain_chr = data[1:0];
                KIND_GXROM:
                begin
                    plain_prg = {1'b0, data[5:4]};
                    plain_chr = data[1:0];
                end
                default: ;
            endcase
        end
    endfunction

    function automatic bank_map_t current_map();
        bank_map_t m;
        m.prg_lo = 5'd0;
        m.prg_hi = (prg_count == 6'd1) ? 5'd0 : 5'd1;
        m.chr_lo = 5'd0;
        m.chr_hi = 5'd1;
        m.mirror = 2'd0;
        case (kind_t'(kind_reg))
            KIND_MMC1:
            begin
                case (prg_mode_t'(mmc1_ctrl[3:2]))
                    PRG_32K_A, PRG_32K_B:
                    begin
                        m.prg_lo = {1'b0, mmc1_prg[3:1], 1'b0};
                        m.prg_hi = m.prg_lo | 5'd1;
                    end
                    PRG_FIX_LO:
                    begin
                        m.prg_lo = 5'd0;
                        m.prg_hi = {1'b0, mmc1_prg};
                    end
                    default:
                    begin
                        m.prg_lo = {1'b0, mmc1_prg};
                        m.prg_hi = last_prg_bank();
                    end
                endcase
                if (mmc1_ctrl[4])
                begin
                    m.chr_lo = mmc1_chr0;
                    m.chr_hi = mmc1_chr1;
                end
                else
                begin
                    m.chr_lo = {mmc1_chr0[4:1], 1'b0};
                    m.chr_hi = m.chr_lo | 5'd1;
                end
                m.mirror = mmc1_ctrl[1:0];
            end
            KIND_UXROM:
            begin
                m.prg_lo = {2'b00, plain_prg};
                m.prg_hi = last_prg_bank();
            end
            KIND_CNROM:
            begin
                m.chr_lo = {2'b00, plain_chr, 1'b0};
                m.chr_hi = m.chr_lo | 5'd1;
            end
            KIND_AXROM:
            begin
                m.prg_lo = {1'b0, plain_prg, 1'b0};
                m.prg_hi = m.prg_lo | 5'd1;
            end
            KIND_GXROM:
            begin
                m.prg_lo = {2'b00, plain_prg[1:0], 1'b0};
                m.prg_hi = m.prg_lo | 5'd1;
                m.chr_lo = {2'b00, plain_chr, 1'b0};
                m.chr_hi = m.chr_lo | 5'd1;
            end
            default: ;
        endcase
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        bank_map_t got;
        bank_map_t want;
        if (!rst_n)
        begin
            kind_reg  = KIND_RESET;
            prg_count = COUNT_RESET;
            shift_reg = SHIFT_EMPTY;
            mmc1_ctrl = CTRL_RESET;
            mmc1_chr0 = 5'd0;
            mmc1_chr1 = 5'd0;
            mmc1_prg  = 4'd0;
            plain_prg = 3'd0;
            plain_chr = 2'd0;
            expected_maps.delete();
            backlog = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAPPER_KIND)
                    kind_reg = cfg_data[2:0];
                else
                    prg_count = cfg_data[5:0];
            end
            if (wr.valid && wr.ready)
            begin
                absorb_write(wr.cpu_address, wr.write_data);
                expected_maps.push_back(current_map());
            end
            if (bank.valid && bank.ready)
            begin
                got = {bank.prg_bank_low, bank.prg_bank_high, bank.chr_bank_low,
                       bank.chr_bank_high, bank.mirror_mode};
                if (expected_maps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected bank map transaction prg %0d/%0d chr %0d/%0d mir %0d",
                             $time, got.prg_lo, got.prg_hi, got.chr_lo, got.chr_hi, got.mirror);
                end
                else
                begin
                    want = expected_maps.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display({"%0t: bank map mismatch: prg_lo exp %0d got %0d, prg_hi exp %0d",
                                  " got %0d, chr_lo exp %0d got %0d, chr_hi exp %0d got %0d,",
                                  " mirror exp %0d got %0d"},
                                 $time, want.prg_lo, got.prg_lo, want.prg_hi, got.prg_hi,
                                 want.chr_lo, got.chr_lo, want.chr_hi, got.chr_hi,
                                 want.mirror, got.mirror);
                    end
                end
            end
            backlog = expected_maps.size();
        end
    end

endmodule

[verif/cartridge_bank_mapper_core_tb.sv]
// Bank mapper testbench top: clock, reset, register setup, CPU write traffic and verdict
module cartridge_bank_mapper_core_tb;
    import cbm_pkg::*;

    localparam int PHASES = 14;
    localparam int PHASE_ITEMS = 27;

    // kind codes outside the named set, expected to fall back to NROM
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam logic [2:0] PHASE_KIND [PHASES] = '{
        KIND_MMC1, KIND_MMC1, KIND_UXROM, KIND_CNROM, KIND_AXROM, KIND_GXROM, KIND_MMC1,
        KIND_UXROM, KIND_SPARE_LO, KIND_GXROM, KIND_SPARE_HI, KIND_MMC1, KIND_NROM, KIND_UXROM
    };
    localparam logic [5:0] PHASE_COUNT [PHASES] = '{
        6'd32, 6'd1, 6'd16, 6'd2, 6'd8, 6'd4, 6'd0,
        6'd63, 6'd5, 6'd33, 6'd2, 6'd20, 6'd1, 6'd0
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatch_count;
    int pending_count;

    cbm_wr_if   wr_ch ();
    cbm_bank_if bank_ch ();

    cartridge_bank_mapper_core #(
        .MAX_PRG_BANKS (32)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr        (wr_ch),
        .bank      (bank_ch)
    );

    cartridge_bank_mapper_core_checker #(
        .MAX_PRG_BANKS (32)
    ) bank_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .wr             (wr_ch),
        .bank           (bank_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        bank_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            bank_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] cart_address();
        return {1'b1, 15'($urandom)};
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            wr_ch.valid <= 1'b0;
            @(negedge clk);
        end
        wr_ch.valid       <= 1'b1;
        wr_ch.cpu_address <= addr;
        wr_ch.write_data  <= data;
        do
            @(posedge clk);
        while (!wr_ch.ready);
        @(negedge clk);
    endtask

    // five serial writes, LSB first; only the last address selects the register
    task automatic mmc1_load(input mmc1_reg_t target, input logic [4:0] value);
        logic [ADDR_W-1:0] addr;
        for (int i = 0; i < 5; i++)
        begin
            addr = cart_address();
            if (i == 4)
                addr[14:13] = target;
            send_write(addr, {1'b0, 6'($urandom), value[i]});
        end
    endtask

    task automatic drain();
        wr_ch.valid <= 1'b0;
        wait (pending_count == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input logic [2:0] kind, input logic [5:0] count);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAPPER_KIND;
        cfg_data  <= CFG_DATA_W'(kind);
        @(negedge clk);
        cfg_index <= CFG_PRG_COUNT;
        cfg_data  <= count;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_traffic(input logic [2:0] kind, input int n);
        int sent;
        int pick;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_write({1'b0, 15'($urandom)}, 8'($urandom));
                sent++;
            end
            else if (kind == KIND_MMC1 && pick < 78)
            begin
                mmc1_load(mmc1_reg_t'($urandom_range(3)), 5'($urandom));
                sent += 5;
            end
            else if (kind == KIND_MMC1 && pick < 88)
            begin
                send_write(cart_address(), {1'b1, 7'($urandom)});
                sent++;
            end
            else
            begin
                send_write(cart_address(), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        cfg_we            = 1'b0;
        cfg_index         = CFG_MAPPER_KIND;
        cfg_data          = '0;
        wr_ch.valid       = 1'b0;
        wr_ch.cpu_address = '0;
        wr_ch.write_data  = '0;
        rst_n             = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // NROM out of reset ignores writes
        send_write(16'h8000, 8'hFF);

        configure(KIND_MMC1, 6'd32);
        send_write(16'h8000, 8'h80);
        // partial load cut short by a reset write
        send_write(16'hFFFF, 8'h01);
        send_write(16'hBFFF, 8'hFF);
        mmc1_load(MMC1_CONTROL, 5'h1F);
        mmc1_load(MMC1_PRG, 5'h1F);
        mmc1_load(MMC1_CHR1, 5'h15);
        send_write(16'h7FFF, 8'h00);

        configure(KIND_UXROM, 6'd1);
        send_write(16'hFFFF, 8'hFF);
        configure(KIND_CNROM, 6'd1);
        send_write(16'h8000, 8'hFF);
        configure(KIND_AXROM, 6'd63);
        send_write(16'hE000, 8'hFF);
        configure(KIND_GXROM, 6'd2);
        send_write(16'hC000, 8'hFF);
        configure(KIND_NROM, 6'd1);
        send_write(16'hA000, 8'h00);

        // state carries over between phases, so each kind also reads the previous kind's state
        for (int p = 0; p < PHASES; p++)
        begin
            configure(PHASE_KIND[p], PHASE_COUNT[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 50;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 50;
                end
                default:
                begin
                    send_idle_pct = 34;
                    stall_pct     = 34;
                end
            endcase
            random_traffic(PHASE_KIND[p], PHASE_ITEMS);
        end

        drain();
        repeat (4) @(negedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_wr_if.sv
rtl/cbm_bank_if.sv
rtl/cartridge_bank_mapper_core.sv
rtl/cbm_checker.sv
verif/cartridge_bank_mapper_core_checker.sv
verif/cartridge_bank_mapper_core_tb.sv
